### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the frame encoder. They sample
// on clk and are held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that a property holds at every clock edge outside reset.
`define BSFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a consequent holds in the same cycle as its antecedent.
`define BSFE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define BSFE_ASSERT(lbl, prop, msg)
`define BSFE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### hdl/bsfe_pkg.sv
// ----------------------------------------------------------------------------
// Frame encoder package
// Codes, line marks, the command record passed from front to back, and the
// helpers that decide byte stuffing.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  // Default sizes.
  localparam int MAX_PAYLOAD_DEF = 252;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Function codes of an input transaction.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Line marks and their escape substitutes.
  localparam logic [7:0] MARK_START = 8'hAF;
  localparam logic [7:0] MARK_END   = 8'hEF;
  localparam logic [7:0] MARK_ESC   = 8'hBF;
  localparam logic [7:0] SUB_START  = 8'hA0;
  localparam logic [7:0] SUB_END    = 8'hE0;
  localparam logic [7:0] SUB_ESC    = 8'hB0;

  // A command holds up to three line tokens.
  localparam int NUM_TOK = 3;

  typedef logic [1:0] tok_idx_t;

  // One token: a byte and whether it goes through stuffing.
  typedef struct packed {
    logic [7:0] value;
    logic       stuff;
  } tok_t;

  // Work for the back end, one per input transaction.
  typedef struct packed {
    tok_t [NUM_TOK-1:0] toks;
    tok_idx_t           last_idx;
    logic               line;
    logic               drop;
  } cmd_t;

  // True for a byte that must be escaped inside frame content.
  function automatic logic is_mark(input logic [7:0] b);
    is_mark = (b == MARK_START) || (b == MARK_END) || (b == MARK_ESC);
  endfunction

  // Substitute byte sent after the escape mark.
  function automatic logic [7:0] sub_of(input logic [7:0] b);
    logic [7:0] s;
    s = SUB_ESC;
    unique case (b)
      MARK_START: s = SUB_START;
      MARK_END:   s = SUB_END;
      default:    s = SUB_ESC;
    endcase
    sub_of = s;
  endfunction

endpackage

### hdl/bsfe_front.sv
// ----------------------------------------------------------------------------
// Frame encoder front end
// Accepts input transactions, keeps the frame state (open flag, running XOR,
// payload count) and turns each transaction into a command for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfe_front #(
  parameter int MaxPayload = bsfe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      func,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      frame_id,
  input  logic            seq_bit,
  input  logic            ack_bit,
  input  logic            force_bit,
  input  logic            q_full,
  output logic            push,
  output bsfe_pkg::cmd_t  push_cmd
);
  import bsfe_pkg::*;

  localparam int CntW = $clog2(MaxPayload + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPayload);

  logic            in_frame;
  logic            in_frame_next;
  logic [7:0]      running_xor;
  logic [7:0]      running_xor_next;
  logic [CntW-1:0] payload_count;
  logic [CntW-1:0] payload_count_next;
  logic [7:0]      hdr;

  // Accept whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign hdr      = {5'd0, force_bit, ack_bit, seq_bit};

  // Classify the transaction and work out the next frame state.
  always_comb begin
    push_cmd           = '0;
    in_frame_next      = in_frame;
    running_xor_next   = running_xor;
    payload_count_next = payload_count;
    unique case (func)
      FUNC_START: begin
        push_cmd.toks[0]   = '{value: MARK_START, stuff: 1'b0};
        push_cmd.toks[1]   = '{value: hdr, stuff: 1'b1};
        push_cmd.toks[2]   = '{value: frame_id, stuff: 1'b1};
        push_cmd.last_idx  = tok_idx_t'(2);
        push_cmd.line      = 1'b1;
        in_frame_next      = 1'b1;
        running_xor_next   = hdr ^ frame_id;
        payload_count_next = '0;
      end
      FUNC_DATA: begin
        if (!in_frame || (payload_count >= CntMax)) begin
          push_cmd.drop = 1'b1;
        end else begin
          push_cmd.toks[0]   = '{value: data_byte, stuff: 1'b1};
          push_cmd.line      = 1'b1;
          running_xor_next   = running_xor ^ data_byte;
          payload_count_next = payload_count + 1'b1;
        end
      end
      FUNC_END: begin
        if (in_frame) begin
          push_cmd.toks[0]   = '{value: running_xor, stuff: 1'b1};
          push_cmd.toks[1]   = '{value: MARK_END, stuff: 1'b0};
          push_cmd.last_idx  = tok_idx_t'(1);
          push_cmd.line      = 1'b1;
          in_frame_next      = 1'b0;
          running_xor_next   = '0;
          payload_count_next = '0;
        end
      end
      default: begin
        push_cmd = '0;
      end
    endcase
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      running_xor   <= '0;
      payload_count <= '0;
    end else if (push) begin
      in_frame      <= in_frame_next;
      running_xor   <= running_xor_next;
      payload_count <= payload_count_next;
    end
  end

  // A closed frame leaves no checksum or count behind.
  `BSFE_ASSERT_IMPL(a_closed_clean, !in_frame, (running_xor == 8'd0) && (payload_count == '0), "closed frame holds stale state")
  // The payload count never passes the limit.
  `BSFE_ASSERT(a_count_limit, payload_count <= CntMax, "payload count beyond limit")
  // A command without line bytes is a single result.
  `BSFE_ASSERT_IMPL(a_null_single, push && !push_cmd.line, push_cmd.last_idx == tok_idx_t'(0), "null command spans several results")

endmodule

### hdl/bsfe_queue.sv
// ----------------------------------------------------------------------------
// Frame encoder command queue
// Short first-in first-out store of commands between the front and back ends.
// ----------------------------------------------------------------------------
module bsfe_queue #(
  parameter int Depth = bsfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsfe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bsfe_pkg::cmd_t head
);
  import bsfe_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### hdl/bsfe_back.sv
// ----------------------------------------------------------------------------
// Frame encoder back end
// Walks the tokens of the head command, inserts escape pairs, and holds each
// result in an output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsfe_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  bsfe_pkg::cmd_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [7:0]     tx_out,
  output logic           out_valid,
  output logic           run_last,
  output logic           dropped
);
  import bsfe_pkg::*;

  tok_idx_t   idx;
  logic       phase;
  tok_t       cur_tok;
  logic       esc_now;
  logic       last_now;
  logic       advance;
  logic [7:0] emit_byte;

  // Current token and what it puts on the line this step.
  assign cur_tok   = head.toks[idx];
  assign esc_now   = cur_tok.stuff && is_mark(cur_tok.value);
  assign last_now  = (idx == head.last_idx) && (!esc_now || phase);
  assign advance   = head_valid && (!res_valid || res_ready);
  assign pop       = advance && last_now;

  always_comb begin
    if (!head.line) begin
      emit_byte = 8'd0;
    end else if (phase) begin
      emit_byte = sub_of(cur_tok.value);
    end else if (esc_now) begin
      emit_byte = MARK_ESC;
    end else begin
      emit_byte = cur_tok.value;
    end
  end

  // Token sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      phase <= 1'b0;
    end else if (advance) begin
      if (esc_now && !phase) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        idx   <= last_now ? '0 : idx + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_out    <= emit_byte;
      out_valid <= head.line;
      run_last  <= last_now;
      dropped   <= head.drop;
    end
  end

  // The second half of an escape pair belongs to a token that needs one.
  `BSFE_ASSERT_IMPL(a_phase_esc, phase, head_valid && esc_now, "substitute step on a plain token")
  // The token index stays within the head command.
  `BSFE_ASSERT_IMPL(a_idx_range, head_valid, idx <= head.last_idx, "token index past last token")
  // An empty queue leaves the sequencer at its start.
  `BSFE_ASSERT_IMPL(a_idle_start, !head_valid, (idx == '0) && !phase, "sequencer busy with no command")
  // A result without a line byte is the only one of its transaction.
  `BSFE_ASSERT_IMPL(a_null_result, res_valid && !out_valid, run_last && (tx_out == 8'd0), "null result malformed")

endmodule

### hdl/byte_stuffing_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// Byte stuffing frame encoder
// Builds transmit frames with start and end marks, escaped content and an XOR
// checksum, from start, payload and end transactions.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   input    in_valid / in_ready   func, data_byte, frame_id, seq/ack/force_bit
//   result   res_valid / res_ready tx_out, out_valid, run_last, dropped
//
// An input transaction yields one to four results, one per cycle from the
// back end's token sequencer while the output register is not stalled; the
// output byte stream sets the rate at which input transactions are taken.
// The front end takes a transaction in any cycle the command queue has room.
// Results sit in an output register; a stall there stops the back end, and
// the input as well once the command queue is full.
// Synchronous reset clears the frame state, the queue and the output valid.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder_unit #(
  parameter int MaxPayload = bsfe_pkg::MAX_PAYLOAD_DEF,
  parameter int QueueDepth = bsfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  input  logic [7:0] frame_id,
  input  logic       seq_bit,
  input  logic       ack_bit,
  input  logic       force_bit,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] tx_out,
  output logic       out_valid,
  output logic       run_last,
  output logic       dropped
);
  import bsfe_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Front end: frame state and classification.
  bsfe_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_byte (data_byte),
    .frame_id  (frame_id),
    .seq_bit   (seq_bit),
    .ack_bit   (ack_bit),
    .force_bit (force_bit),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Command queue between the two ends.
  bsfe_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: stuffing and result output.
  bsfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .tx_out     (tx_out),
    .out_valid  (out_valid),
    .run_last   (run_last),
    .dropped    (dropped)
  );

endmodule
